[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the ring hole correlation score block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define RHCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define RHCS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RHCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHCS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/rhcs_pkg.sv]
// ---------------------------------------------------------------------------
// rhcs_pkg
// Types and constants shared by the ring hole correlation score modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rhcs_pkg;

  localparam int          MAX_POINTS_DEF = 128;
  localparam logic [7:0]  POINT_COUNT_RST = 8'd100;
  localparam logic [7:0]  PIX_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_VARIANCE = 2'd1,
    ST_NEGCORR  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_CHK,
    BK_SQRT,
    BK_DIV1,
    BK_MLO,
    BK_MHI,
    BK_DIV2,
    BK_FIN
  } back_state_e;

  // Accumulated totals of one finished set plus the clamped point count.
  typedef struct packed {
    logic [14:0] hole_sum;
    logic [14:0] ring_sum;
    logic [15:0] total_sum;
    logic [23:0] square_sum;
    logic [7:0]  hole_min;
    logic [7:0]  ring_max;
    logic [7:0]  n;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/rhcs_front.sv]
// ---------------------------------------------------------------------------
// rhcs_front
// Accepts pixels, keeps the running sums and extremes, and hands a snapshot
// of each finished set to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rhcs_front #(
  parameter int MAX_POINTS = rhcs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         pixel_i,
  input  logic               is_ring_i,
  input  logic               last_i,
  input  rhcs_pkg::fifo_stat_t fifo_st_i,
  output logic               push_o,
  output rhcs_pkg::snap_t    snap_o
);
  import rhcs_pkg::*;

  localparam logic [7:0] NMAX = (MAX_POINTS > 255) ? 8'd255 : 8'(MAX_POINTS);

  logic [7:0]  pc_q;
  logic [14:0] hs_q, hs_d, rs_q, rs_d;
  logic [15:0] bs_q, bs_d;
  logic [23:0] qs_q, qs_d;
  logic [7:0]  hmin_q, hmin_d, rmax_q, rmax_d;
  logic [7:0]  n_clamp;
  logic [15:0] sq;
  logic        accept;

  assign in_stall_o = fifo_st_i.full;
  assign accept     = in_valid_i && !fifo_st_i.full;
  assign push_o     = accept && last_i;
  assign sq         = {8'b0, pixel_i} * {8'b0, pixel_i};

  always_comb begin
    hs_d   = hs_q;
    rs_d   = rs_q;
    hmin_d = hmin_q;
    rmax_d = rmax_q;
    if (is_ring_i) begin
      rs_d = rs_q + {7'b0, pixel_i};
      if (pixel_i > rmax_q) rmax_d = pixel_i;
    end else begin
      hs_d = hs_q + {7'b0, pixel_i};
      if (pixel_i < hmin_q) hmin_d = pixel_i;
    end
    bs_d = bs_q + {8'b0, pixel_i};
    qs_d = qs_q + {8'b0, sq};
  end

  always_comb begin
    if (pc_q == 8'd0) begin
      n_clamp = 8'd1;
    end else if (pc_q > NMAX) begin
      n_clamp = NMAX;
    end else begin
      n_clamp = pc_q;
    end
  end

  assign snap_o = '{hole_sum: hs_d, ring_sum: rs_d, total_sum: bs_d, square_sum: qs_d,
                    hole_min: hmin_d, ring_max: rmax_d, n: n_clamp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= POINT_COUNT_RST;
      hs_q   <= '0;
      rs_q   <= '0;
      bs_q   <= '0;
      qs_q   <= '0;
      hmin_q <= PIX_MAX;
      rmax_q <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      if (accept) begin
        if (last_i) begin
          hs_q   <= '0;
          rs_q   <= '0;
          bs_q   <= '0;
          qs_q   <= '0;
          hmin_q <= PIX_MAX;
          rmax_q <= '0;
        end else begin
          hs_q   <= hs_d;
          rs_q   <= rs_d;
          bs_q   <= bs_d;
          qs_q   <= qs_d;
          hmin_q <= hmin_d;
          rmax_q <= rmax_d;
        end
      end
    end
  end

endmodule

[rtl/rhcs_fifo.sv]
// ---------------------------------------------------------------------------
// rhcs_fifo
// Two-entry queue of set snapshots between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rhcs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rhcs_pkg::snap_t      wdata_i,
  input  logic                 pop_i,
  output rhcs_pkg::snap_t      rdata_o,
  output rhcs_pkg::fifo_stat_t stat_o
);
  import rhcs_pkg::*;

  snap_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign rdata_o      = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[rtl/rhcs_back.sv]
// ---------------------------------------------------------------------------
// rhcs_back
// Scores one snapshot: variance, bit-serial square root, two restoring
// divisions sharing one divider, split multiply, and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rhcs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rhcs_pkg::fifo_stat_t fifo_st_i,
  input  rhcs_pkg::snap_t      snap_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   score_o,
  output logic [1:0]           status_o
);
  import rhcs_pkg::*;

  back_state_e st_q, st_d;
  snap_t       sn_q;
  logic [32:0] tnq_q;
  logic [31:0] bsq_q;
  logic [15:0] dv_q;
  logic [22:0] rm_q;
  logic        neg_q;
  logic [1:0]  stat_q;
  logic [48:0] sv_q;
  logic [49:0] sr_q, sb_q;
  logic [63:0] num_q;
  logic [24:0] rem_q, dsr_q;
  logic [5:0]  cnt_q;
  logic [39:0] c_q;
  logic [62:0] prod_q;
  logic        ov_q;
  logic signed [31:0] score_q;
  logic [1:0]  ostat_q;

  logic [49:0] s_sum;
  logic        s_ge;
  logic [25:0] d_trial;
  logic        d_ge;
  logic [24:0] d_rem;
  logic [16:0] d2r;
  logic        dneg;
  logic [7:0]  mag;
  logic        cneg;
  logic [32:0] vdiff;
  logic [14:0] hc;
  logic [54:0] qv;
  logic signed [31:0] sat;
  logic        fin_go;

  assign s_sum   = sr_q + sb_q;
  assign s_ge    = {1'b0, sv_q} >= s_sum;
  assign d_trial = {rem_q, num_q[63]};
  assign d_ge    = d_trial >= {1'b0, dsr_q};
  assign d_rem   = d_ge ? 25'(d_trial - {1'b0, dsr_q}) : d_trial[24:0];
  assign d2r     = {1'b0, sn_q.ring_sum, 1'b0} - {1'b0, sn_q.total_sum};
  assign dneg    = d2r[16];
  assign cneg    = sn_q.ring_max < sn_q.hole_min;
  assign mag     = cneg ? (sn_q.hole_min - sn_q.ring_max) : (sn_q.ring_max - sn_q.hole_min);
  assign vdiff   = tnq_q - {1'b0, bsq_q};
  assign hc      = (sn_q.hole_sum < 15'd2) ? 15'd2 : sn_q.hole_sum;
  assign qv      = num_q[54:0];
  assign fin_go  = !out_valid_o || !out_stall_i;
  assign pop_o   = (st_q == BK_IDLE) && !fifo_st_i.empty;

  always_comb begin
    if (!neg_q) begin
      sat = (qv > 55'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(qv[31:0]);
    end else begin
      sat = (qv > 55'h8000_0000) ? 32'sh8000_0000 : signed'(32'(-qv[31:0]));
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (!fifo_st_i.empty) st_d = BK_MUL;
      BK_MUL:  st_d = BK_CHK;
      BK_CHK: begin
        if (tnq_q <= {1'b0, bsq_q} || dneg) begin
          st_d = BK_FIN;
        end else begin
          st_d = BK_SQRT;
        end
      end
      BK_SQRT: if (cnt_q == 6'd0) st_d = BK_DIV1;
      BK_DIV1: if (cnt_q == 6'd0) st_d = BK_MLO;
      BK_MLO:  st_d = BK_MHI;
      BK_MHI:  st_d = BK_DIV2;
      BK_DIV2: if (cnt_q == 6'd0) st_d = BK_FIN;
      BK_FIN:  if (fin_go) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  // Datapath registers, loaded per state.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      BK_IDLE: sn_q <= snap_i;
      BK_MUL: begin
        tnq_q <= {24'b0, sn_q.n, 1'b0} * {9'b0, sn_q.square_sum};
        bsq_q <= {16'b0, sn_q.total_sum} * {16'b0, sn_q.total_sum};
        rm_q  <= {8'b0, sn_q.ring_sum} * {15'b0, mag};
        neg_q <= 1'b0;
        num_q <= '0;
      end
      BK_CHK: begin
        dv_q <= d2r[15:0];
        if (tnq_q <= {1'b0, bsq_q}) begin
          stat_q <= ST_VARIANCE;
        end else if (dneg) begin
          stat_q <= ST_NEGCORR;
        end else begin
          stat_q <= ST_VALID;
        end
        sv_q  <= {vdiff, 16'b0};
        sr_q  <= '0;
        sb_q  <= 50'd1 << 48;
        cnt_q <= 6'd24;
      end
      BK_SQRT: begin
        if (s_ge) begin
          sv_q <= sv_q - s_sum[48:0];
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
        if (cnt_q == 6'd0) begin
          dsr_q <= (sr_q[24:0] == 25'd0 && !s_ge) ? 25'd1
                 : (s_ge ? 25'((sr_q >> 1) + sb_q) : 25'(sr_q >> 1));
          num_q <= {24'b0, dv_q, 24'b0};
          rem_q <= '0;
          cnt_q <= 6'd63;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
      BK_DIV1, BK_DIV2: begin
        rem_q <= d_rem;
        num_q <= {num_q[62:0], d_ge};
        cnt_q <= cnt_q - 6'd1;
        if (st_q == BK_DIV1 && cnt_q == 6'd0) c_q <= {num_q[38:0], d_ge};
      end
      BK_MLO: begin
        prod_q <= 63'({20'b0, rm_q} * {23'b0, c_q[19:0]});
        neg_q  <= cneg;
      end
      BK_MHI: begin
        prod_q <= prod_q + {43'({20'b0, rm_q} * {23'b0, c_q[39:20]}), 20'b0};
        num_q  <= {9'b0,
                   55'((prod_q + {43'({20'b0, rm_q} * {23'b0, c_q[39:20]}), 20'b0}) >> 8)};
        rem_q  <= '0;
        dsr_q  <= {10'b0, hc};
        cnt_q  <= 6'd63;
      end
      BK_FIN: ;
      default: ;
    endcase
    if (st_q == BK_FIN && fin_go) begin
      score_q <= sat;
      ostat_q <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_FIN && fin_go) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign score_o     = score_q;
  assign status_o    = ostat_q;

endmodule

[rtl/ring_hole_correlation_score.sv]
// ---------------------------------------------------------------------------
// ring_hole_correlation_score
// Normalized correlation score of a ring-around-a-hole pixel pattern.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   pixel_i, is_ring_i, last_i
// out       output     out_valid_o / out_stall_i score_o, status_o
// cfg       input      cfg_we_i                  cfg_wdata_i (point count)
//
// The front takes one pixel transfer per cycle while in_stall_o is low, and folds
// it into the sums. A transfer marked last queues a snapshot; scoring a valid set
// runs the 25-step square root and two 64-step divisions of the shared divider.
// The two-entry queue lets the next set accumulate meanwhile.
// Reset (rst_ni low) clears sums, queue and output and sets the count to 100.
// in_stall_o rises only while the queue holds two unscored sets.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ring_hole_correlation_score #(
  parameter int MAX_POINTS = rhcs_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         pixel_i,
  input  logic               is_ring_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] score_o,
  output logic [1:0]         status_o
);
  import rhcs_pkg::*;

  // Snapshot path from the front through the queue to the back.
  logic       push, pop;
  snap_t      snap_w, snap_r;
  fifo_stat_t fifo_st;

  rhcs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .pixel_i, .is_ring_i, .last_i,
    .fifo_st_i(fifo_st), .push_o(push), .snap_o(snap_w)
  );

  rhcs_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(snap_w),
    .pop_i(pop), .rdata_o(snap_r), .stat_o(fifo_st)
  );

  rhcs_back u_back (
    .clk_i, .rst_ni, .fifo_st_i(fifo_st), .snap_i(snap_r), .pop_o(pop),
    .out_valid_o, .out_stall_i, .score_o, .status_o
  );

  // A failed score always carries a zero value.
  `RHCS_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_o && status_o != 2'(ST_VALID)) |-> (score_o == 32'sd0), "nonzero score with failure status")
  // The queue is never written while full.
  `RHCS_NEVER(a_no_overflow, clk_i, rst_ni, push && fifo_st.full, "queue overflow")
  // The back only takes a snapshot that is there.
  `RHCS_NEVER(a_no_underflow, clk_i, rst_ni, pop && fifo_st.empty, "queue underflow")
  // A snapshot is queued only by an accepted last transfer.
  `RHCS_ASSERT(a_push_src, clk_i, rst_ni, push |-> (in_valid_i && !in_stall_o && last_i), "stray queue write")

endmodule

[test/ring_hole_correlation_score_test.sv]
// ---------------------------------------------------------------------------
// ring_hole_correlation_score_test
// Self-checking bench for the ring hole correlation score block: a queue-fed
// driver and a clocked monitor, with a behavioral score predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ring_hole_correlation_score_test;
  import rhcs_pkg::*;

  typedef struct packed {
    logic [7:0] pixel;
    logic       is_ring;
    logic       last;
  } pixel_item_t;

  typedef struct packed {
    logic signed [31:0] score;
    status_e            status;
  } score_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [7:0]         cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         pixel_i;
  logic               is_ring_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] score_o;
  logic [1:0]         status_o;

  ring_hole_correlation_score dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .is_ring_i   (is_ring_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .score_o     (score_o),
    .status_o    (status_o)
  );

  // Items waiting to be offered, and scores still owed by the block.
  pixel_item_t   pending_pixels[$];
  score_result_t expected_scores[$];
  int            mismatch_count = 0;

  // Predictor state: a private copy of the point count and the set sums.
  logic [7:0]  point_count_reg;
  logic [14:0] hole_acc;
  logic [14:0] ring_acc;
  logic [15:0] total_acc;
  logic [23:0] square_acc;
  logic [7:0]  hole_low;
  logic [7:0]  ring_high;

  // Long receiver hold-off, requested by the sequence and timed by its own process.
  logic rx_hold_req;
  logic sender_pause;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic clear_sums();
    hole_acc   = '0;
    ring_acc   = '0;
    total_acc  = '0;
    square_acc = '0;
    hole_low   = PIX_MAX;
    ring_high  = '0;
  endtask

  // Folds one accepted pixel into the sums; a last pixel also scores the set.
  task automatic predict_score(input pixel_item_t it);
    longint unsigned n;
    longint unsigned two_nq;
    longint unsigned bsq;
    longint unsigned root;
    longint unsigned corr;
    longint unsigned hole_c;
    longint unsigned mag;
    longint unsigned q;
    longint signed   diff;
    longint signed   contrast;
    score_result_t   res;
    if (it.is_ring) begin
      ring_acc = ring_acc + 15'(it.pixel);
      if (it.pixel > ring_high) ring_high = it.pixel;
    end else begin
      hole_acc = hole_acc + 15'(it.pixel);
      if (it.pixel < hole_low) hole_low = it.pixel;
    end
    total_acc  = total_acc + 16'(it.pixel);
    square_acc = square_acc + 24'(16'(it.pixel) * 16'(it.pixel));
    if (!it.last) return;

    n = point_count_reg;
    if (n < 1) n = 1;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    two_nq = 2 * n * longint'(square_acc);
    bsq    = longint'(total_acc) * longint'(total_acc);
    diff   = 2 * longint'(ring_acc) - longint'(total_acc);
    res.score = '0;
    if (two_nq <= bsq) begin
      res.status = ST_VARIANCE;
    end else if (diff < 0) begin
      res.status = ST_NEGCORR;
    end else begin
      res.status = ST_VALID;
      root = int_sqrt((two_nq - bsq) << 16);
      if (root == 0) root = 1;
      corr     = (longint'(diff) << 24) / root;
      hole_c   = (hole_acc < 2) ? 2 : longint'(hole_acc);
      contrast = longint'(ring_high) - longint'(hole_low);
      mag      = (contrast < 0) ? -contrast : contrast;
      q        = longint'(ring_acc) * mag * corr / (hole_c * 256);
      if (contrast >= 0) begin
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        res.score = q[31:0];
      end else begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        res.score = 32'(64'd0 - q);
      end
    end
    expected_scores.push_back(res);
    clear_sums();
  endtask

  // Mostly short gaps, a few long ones, and calm stretches with none at all.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: holds a stalled transfer steady, otherwise offers the next item.
  int tx_gap;
  int tx_stretch;
  bit tx_calm;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pixel_i    <= '0;
      is_ring_i  <= 1'b0;
      last_i     <= 1'b0;
      tx_gap     = 0;
      tx_stretch = 0;
      tx_calm    = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_score('{pixel: pixel_i, is_ring: is_ring_i, last: last_i});
      end
      if (tx_stretch == 0) begin
        tx_stretch = $urandom_range(30, 200);
        tx_calm    = ($urandom_range(0, 3) == 0);
      end else begin
        tx_stretch--;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0 && !sender_pause) begin
          it = pending_pixels.pop_front();
          pixel_i    <= it.pixel;
          is_ring_i  <= it.is_ring;
          last_i     <= it.last;
          in_valid_i <= 1'b1;
          tx_gap     = pick_gap(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each transfer on the result side against the oldest expectation.
  int rx_gap;
  int rx_stretch;
  bit rx_calm;
  always @(posedge clk_i or negedge rst_ni) begin
    score_result_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap     = 0;
      rx_stretch = 0;
      rx_calm    = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: score %0d status %0d", score_o, status_o);
        end else begin
          exp_res = expected_scores.pop_front();
          if (score_o !== exp_res.score || status_o !== exp_res.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Result mismatch: expected score %0d status %0d, got score %0d status %0d",
                       exp_res.score, exp_res.status, score_o, status_o);
          end
        end
      end
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(30, 200);
        rx_calm    = ($urandom_range(0, 3) == 0);
      end else begin
        rx_stretch--;
      end
      if (rx_gap > 0) rx_gap--;
      else rx_gap = pick_gap(rx_calm);
      out_stall_i <= rx_hold_req || (rx_gap > 0);
    end
  end

  // The long hold-off is counted here so the sender keeps running meanwhile.
  initial begin
    wait (rx_hold_req === 1'b1);
    repeat (800) @(posedge clk_i);
    rx_hold_req <= 1'b0;
  end

  task automatic add_pixel(input int px, input bit ring, input bit last);
    pending_pixels.push_back('{pixel: 8'(px), is_ring: ring, last: last});
  endtask

  // One set of hole and ring samples; dark holes and bright rings unless noisy.
  task automatic add_set(input int count, input bit noisy);
    bit ring;
    for (int i = 0; i < count; i++) begin
      ring = $urandom_range(0, 1);
      if (noisy) add_pixel($urandom_range(0, 255), ring, 1'b0);
      else if (ring) add_pixel($urandom_range(150, 255), 1'b1, 1'b0);
      else add_pixel($urandom_range(0, 90), 1'b0, 1'b0);
    end
    add_pixel($urandom_range(0, 255), $urandom_range(0, 1), 1'b1);
  endtask

  task automatic write_point_count(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    point_count_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every item went out and every score came back, then lets the
  // scoring pipeline drain before the register may change.
  task automatic wait_idle();
    @(posedge clk_i);
    wait (pending_pixels.size() == 0 && !in_valid_i && expected_scores.size() == 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic add_random_sets(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if ($urandom_range(0, 9) < 2) begin
        // Broken sequence: random content with stray last flags.
        for (int i = 0; i < len; i++)
          add_pixel($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 19) == 0);
      end else begin
        add_set(len, $urandom_range(0, 4) == 0);
      end
      sent += len + 1;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rx_hold_req  = 1'b0;
    sender_pause = 1'b0;
    point_count_reg = POINT_COUNT_RST;
    clear_sums();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets under the reset point count.
    add_pixel(0, 1'b0, 1'b0);
    add_pixel(255, 1'b1, 1'b1);            // ideal template
    add_pixel(255, 1'b0, 1'b1);            // one hole sample only: negative correlation
    add_pixel(250, 1'b0, 1'b0);
    add_pixel(10, 1'b1, 1'b1);             // bright hole, dark ring: negative correlation
    add_pixel(100, 1'b1, 1'b0);
    add_pixel(128, 1'b1, 1'b1);            // no hole samples at all
    add_pixel(100, 1'b1, 1'b0);
    add_pixel(100, 1'b1, 1'b0);
    add_pixel(90, 1'b1, 1'b0);
    add_pixel(200, 1'b0, 1'b1);            // ring max below hole min: negative contrast
    add_pixel(0, 1'b0, 1'b0);
    add_pixel(1, 1'b0, 1'b0);
    add_pixel(254, 1'b1, 1'b1);            // hole sum below the clamp
    add_pixel(0, 1'b0, 1'b1);              // all zero: no variance
    wait_idle();

    // Register extremes, with random sets under each.
    write_point_count(8'd0);
    add_random_sets(60);
    wait_idle();
    write_point_count(8'd255);
    add_random_sets(60);
    wait_idle();
    write_point_count(8'd129);
    add_random_sets(40);
    wait_idle();

    // Sums wrap: a long set of full-scale pixels.
    write_point_count(8'd128);
    for (int i = 0; i < 300; i++) add_pixel(255, i[0], 1'b0);
    add_pixel(255, 1'b1, 1'b1);
    wait_idle();

    // Receiver holds off while short sets keep arriving, filling the block.
    write_point_count(8'd1);
    rx_hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) add_set(1, 1'b0);
    wait_idle();

    // Sender pauses mid-stream until every score is back.
    write_point_count(8'd2);
    add_random_sets(40);
    wait (pending_pixels.size() <= 20);
    sender_pause = 1'b1;
    wait (expected_scores.size() == 0);
    repeat (50) @(posedge clk_i);
    sender_pause = 1'b0;
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      write_point_count(8'($urandom_range(1, 40)));
      add_random_sets(30);
      wait_idle();
    end
    write_point_count(8'($urandom_range(0, 255)));
    add_random_sets(60);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
